// ===== rtl/yld_pkg.sv =====
package yld_pkg;

    localparam int SIZE_W = 12;
    localparam int PIX_W  = 8;

    // source size after reset
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    typedef enum logic [0:0]
    {
        REG_SOURCE_WIDTH  = 1'b0,
        REG_SOURCE_HEIGHT = 1'b1
    } yld_reg_t;

    // effective source size and its quotient and remainder by the output size
    typedef struct packed
    {
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] quot;
        logic [SIZE_W-1:0] rem;
    } yld_scale_t;

    typedef struct packed
    {
        logic [PIX_W-1:0] luma;
        logic             frame_start;
    } yld_pix_t;

endpackage

// ===== rtl/yld_cfg.sv =====
module yld_cfg #(
    parameter int OUT_SIZE   = 128,
    parameter int RESET_SIZE = 640,
    parameter yld_pkg::yld_reg_t REG_SEL = yld_pkg::REG_SOURCE_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [yld_pkg::SIZE_W-1:0] cfg_data,
    output yld_pkg::yld_scale_t       scale
);
    import yld_pkg::*;

    // reciprocal of the output size, exact for every 12-bit dividend
    localparam int LOG_D  = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 0;
    localparam int SHIFT  = SIZE_W + LOG_D;
    localparam int PROD_W = SHIFT + SIZE_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(OUT_SIZE) - 64'd1) / 64'(OUT_SIZE);
    localparam logic [PROD_W-1:0] RECIP = RECIP_FULL[PROD_W-1:0];
    localparam logic [SIZE_W-1:0] OUT_K = SIZE_W'(OUT_SIZE);

    localparam yld_scale_t RESET_SCALE = '{
        size: SIZE_W'(RESET_SIZE),
        quot: SIZE_W'(RESET_SIZE / OUT_SIZE),
        rem:  SIZE_W'(RESET_SIZE % OUT_SIZE)
    };

    logic [SIZE_W-1:0] eff_size;
    logic [PROD_W-1:0] prod;
    yld_scale_t        scale_reg;
    yld_scale_t        scale_next;

    always_comb
    begin
        // a size of zero behaves as one
        eff_size = (cfg_data == '0) ? SIZE_W'(1) : cfg_data;
        prod = PROD_W'(eff_size) * RECIP;
        scale_next.size = eff_size;
        scale_next.quot = prod[SHIFT +: SIZE_W];
        scale_next.rem  = eff_size - scale_next.quot * OUT_K;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= RESET_SCALE;
        end
        else if (cfg_we && (cfg_index == REG_SEL))
        begin
            scale_reg <= scale_next;
        end
    end

    assign scale = scale_reg;

endmodule

// ===== rtl/yld_sel.sv =====
module yld_sel #(
    parameter int OUT_WIDTH  = 128,
    parameter int OUT_HEIGHT = 112
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pix_valid,
    input  yld_pkg::yld_pix_t        pix,
    output logic                     pix_adv,
    input  yld_pkg::yld_scale_t      col_scale,
    input  yld_pkg::yld_scale_t      row_scale,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [yld_pkg::PIX_W-1:0] out_gray,
    output logic                     out_eor,
    output logic                     out_eof
);
    import yld_pkg::*;

    localparam int OCOL_W = $clog2(OUT_WIDTH + 1);
    localparam int OROW_W = $clog2(OUT_HEIGHT + 1);
    localparam int CREM_W = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
    localparam int RREM_W = (OUT_HEIGHT > 1) ? $clog2(OUT_HEIGHT) : 1;

    localparam logic [OCOL_W-1:0] OW_K    = OCOL_W'(OUT_WIDTH);
    localparam logic [OCOL_W-1:0] OW_LAST = OCOL_W'(OUT_WIDTH - 1);
    localparam logic [OROW_W-1:0] OH_K    = OROW_W'(OUT_HEIGHT);
    localparam logic [OROW_W-1:0] OH_LAST = OROW_W'(OUT_HEIGHT - 1);
    localparam logic [CREM_W:0]   OW_REM  = (CREM_W + 1)'(OUT_WIDTH);
    localparam logic [RREM_W:0]   OH_REM  = (RREM_W + 1)'(OUT_HEIGHT);

    logic [SIZE_W-1:0] scol_reg, scol_next, srow_reg, srow_next;
    logic [SIZE_W-1:0] pcol_reg, pcol_next, prow_reg, prow_next;
    logic [OCOL_W-1:0] ocol_reg, ocol_next;
    logic [OROW_W-1:0] orow_reg, orow_next;
    logic [CREM_W-1:0] crem_reg, crem_next;
    logic [RREM_W-1:0] rrem_reg, rrem_next;

    logic [SIZE_W-1:0] cur_scol, cur_srow, cur_pcol, cur_prow;
    logic [OCOL_W-1:0] cur_ocol;
    logic [OROW_W-1:0] cur_orow;
    logic [CREM_W-1:0] cur_crem;
    logic [RREM_W-1:0] cur_rrem;

    logic              pick_row, hit, eor, eof, row_end;
    logic [CREM_W:0]   csum;
    logic [RREM_W:0]   rsum;
    logic              ccarry, rcarry;
    logic              out_free;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_gray_reg;
    logic              out_eor_reg, out_eof_reg;

    always_comb
    begin
        // frame start restarts everything before the pixel is judged
        cur_scol = pix.frame_start ? '0 : scol_reg;
        cur_srow = pix.frame_start ? '0 : srow_reg;
        cur_pcol = pix.frame_start ? '0 : pcol_reg;
        cur_prow = pix.frame_start ? '0 : prow_reg;
        cur_ocol = pix.frame_start ? '0 : ocol_reg;
        cur_orow = pix.frame_start ? '0 : orow_reg;
        cur_crem = pix.frame_start ? '0 : crem_reg;
        cur_rrem = pix.frame_start ? '0 : rrem_reg;

        pick_row = (cur_orow < OH_K) && (cur_srow == cur_prow);
        hit = pick_row && (cur_ocol < OW_K) && (cur_scol == cur_pcol);
        eor = (cur_ocol == OW_LAST);
        eof = eor && (cur_orow == OH_LAST);
        row_end = ({1'b0, cur_scol} + (SIZE_W + 1)'(1)) >= {1'b0, col_scale.size};

        // incremental floor(k * size / out): quotient plus carry from remainder
        csum = {1'b0, cur_crem} + (CREM_W + 1)'(col_scale.rem);
        ccarry = (csum >= OW_REM);
        rsum = {1'b0, cur_rrem} + (RREM_W + 1)'(row_scale.rem);
        rcarry = (rsum >= OH_REM);

        scol_next = cur_scol;
        srow_next = cur_srow;
        pcol_next = cur_pcol;
        prow_next = cur_prow;
        ocol_next = cur_ocol;
        orow_next = cur_orow;
        crem_next = cur_crem;
        rrem_next = cur_rrem;

        if (hit)
        begin
            ocol_next = cur_ocol + OCOL_W'(1);
            pcol_next = cur_pcol + col_scale.quot + SIZE_W'(ccarry);
            crem_next = ccarry ? CREM_W'(csum - OW_REM) : CREM_W'(csum);
        end

        if (row_end)
        begin
            scol_next = '0;
            srow_next = cur_srow + SIZE_W'(1);
            if (pick_row)
            begin
                orow_next = cur_orow + OROW_W'(1);
                ocol_next = '0;
                pcol_next = '0;
                crem_next = '0;
                prow_next = cur_prow + row_scale.quot + SIZE_W'(rcarry);
                rrem_next = rcarry ? RREM_W'(rsum - OH_REM) : RREM_W'(rsum);
            end
        end
        else
        begin
            scol_next = cur_scol + SIZE_W'(1);
        end

        out_free = !out_valid_reg || out_ready;
        pix_adv = pix_valid && (!hit || out_free);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scol_reg <= '0;
            srow_reg <= '0;
            pcol_reg <= '0;
            prow_reg <= '0;
            ocol_reg <= '0;
            orow_reg <= '0;
            crem_reg <= '0;
            rrem_reg <= '0;
        end
        else if (pix_adv)
        begin
            scol_reg <= scol_next;
            srow_reg <= srow_next;
            pcol_reg <= pcol_next;
            prow_reg <= prow_next;
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
            crem_reg <= crem_next;
            rrem_reg <= rrem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pix_adv && hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_adv && hit)
        begin
            out_gray_reg <= pix.luma;
            out_eor_reg  <= eor;
            out_eof_reg  <= eof;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_gray  = out_gray_reg;
    assign out_eor   = out_eor_reg;
    assign out_eof   = out_eof_reg;

endmodule

// ===== rtl/yuyv_luma_nearest_downscaler.sv =====
// a source beat is held in the input register, then a picked one in the result register
// throughput: one source pixel per cycle; a picked pixel stalls while a result beat waits
// pixels that are not picked keep flowing while a result beat waits on m_axis_tready
// reset: counters and picks clear, source size returns to 640 x 480
module yuyv_luma_nearest_downscaler #(
    parameter int OUT_WIDTH  = 128,
    parameter int OUT_HEIGHT = 112
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [15:0]                s_axis_tdata,   // [15:8] chroma_byte, [7:0] luma_byte
    input  logic                       s_axis_tuser,   // frame_start
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // gray_pixel
    output logic                       m_axis_tuser,   // end_of_row
    output logic                       m_axis_tlast,   // end_of_frame
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [yld_pkg::SIZE_W-1:0] cfg_data
);
    import yld_pkg::*;

    logic       in_valid_reg;
    yld_pix_t   in_pix_reg;
    logic       pix_adv;
    yld_scale_t col_scale, row_scale;

    // chroma byte is dropped at the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (pix_adv)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_pix_reg.luma        <= s_axis_tdata[PIX_W-1:0];
            in_pix_reg.frame_start <= s_axis_tuser;
        end
    end

    assign s_axis_tready = !in_valid_reg || pix_adv;

    yld_cfg #(
        .OUT_SIZE   (OUT_WIDTH),
        .RESET_SIZE (RESET_WIDTH),
        .REG_SEL    (REG_SOURCE_WIDTH)
    ) u_cfg_width (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .scale     (col_scale)
    );

    yld_cfg #(
        .OUT_SIZE   (OUT_HEIGHT),
        .RESET_SIZE (RESET_HEIGHT),
        .REG_SEL    (REG_SOURCE_HEIGHT)
    ) u_cfg_height (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .scale     (row_scale)
    );

    yld_sel #(
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT)
    ) u_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (in_valid_reg),
        .pix       (in_pix_reg),
        .pix_adv   (pix_adv),
        .col_scale (col_scale),
        .row_scale (row_scale),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_gray  (m_axis_tdata),
        .out_eor   (m_axis_tuser),
        .out_eof   (m_axis_tlast)
    );

endmodule
